// ===== src/afr_pkg.sv =====
// Shared types and constants for the API frame receiver.
`timescale 1ns / 1ps

package afr_pkg;

  localparam logic [7:0] START_MARK       = 8'h7E;
  localparam logic [7:0] SUM_BASE         = 8'hFF;
  localparam logic [7:0] MIN_LENGTH_RESET = 8'd3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_SHORT = 2'd3
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
  } result_t;

endpackage

// ===== src/afr_core.sv =====
// Frame parsing state machine: one received byte per step, at most one result.
`timescale 1ns / 1ps

module afr_core
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic [7:0] min_length,
  output result_t    result
);

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] count_inc;

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    case (phase)
      PH_LEN_HI: begin
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (byte_in < min_length) begin
          phase_next = PH_HUNT;
        end else begin
          frame_length_next = byte_in;
          byte_count_next   = 8'd0;
          running_sum_next  = 8'd0;
          phase_next        = (byte_in == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + byte_in;
        byte_count_next  = count_inc;
        if (count_inc == frame_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (byte_in == START_MARK) ? PH_LEN_HI : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    result       = '0;
    result.kind  = KIND_BYTE;
    case (phase)
      PH_LEN_LO: begin
        if (byte_in < min_length) begin
          result.valid = 1'b1;
          result.kind  = KIND_SHORT;
          result.data  = byte_in;
          result.last  = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        result.valid = 1'b1;
        result.kind  = KIND_BYTE;
        result.data  = byte_in;
        result.index = byte_count;
      end
      PH_CHECK: begin
        result.valid = 1'b1;
        result.kind  = ((SUM_BASE - running_sum) == byte_in) ? KIND_GOOD : KIND_BAD;
        result.data  = frame_length;
        result.last  = 1'b1;
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= 8'd0;
      byte_count   <= 8'd0;
      running_sum  <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

// ===== src/api_frame_receiver.sv =====
// Top level of the API frame receiver: input register, parser, result register.
//
//   channel   direction  handshake              payload
//   in        receive    in_valid / in_stall    rx_byte
//   out       send       out_valid / out_stall  kind, data, index, last
//   cfg       receive    cfg_write              cfg_data (min_length)
//
// One byte per cycle sustained while out is not stalled; a byte is parsed when
// the parser steps on it, and its result, if any, stands at out from that step.
// rst is synchronous: hunt for the start byte, min_length back to 3.
// A stalled result holds the parser; in_stall rises once the input register
// is also full, so no byte is lost.
`timescale 1ns / 1ps

module api_frame_receiver
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic [7:0] index,
  output logic       last,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  logic       in_full;
  logic [7:0] in_byte;
  logic [7:0] min_length;
  logic       step;
  logic       take_in;
  result_t    result;

  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !step;
  assign take_in  = in_valid && !in_stall;

  afr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_in    (in_byte),
    .min_length (min_length),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (cfg_write) begin
      min_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      kind  <= result.kind;
      data  <= result.data;
      index <= result.index;
      last  <= result.last;
    end
  end

endmodule

// ===== dv/api_frame_receiver_checker.sv =====
// Checker for the API frame receiver: tracks the deframing and compares every output transfer.
`timescale 1ns / 1ps

module api_frame_receiver_checker
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic [7:0] index,
  input  logic       last,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         expected_left
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
  } frame_result_t;

  frame_result_t expected_q[$];
  phase_t        parse_phase;
  logic [7:0]    min_len;
  logic [7:0]    frame_len;
  logic [7:0]    byte_cnt;
  logic [7:0]    byte_sum;

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                       output frame_result_t res);
    logic [7:0] want_sum;
    produced = 1'b0;
    res      = '0;
    case (parse_phase)
      PH_LEN_HI: parse_phase = PH_LEN_LO;
      PH_LEN_LO: begin
        if (b < min_len) begin
          parse_phase = PH_HUNT;
          produced    = 1'b1;
          res         = '{KIND_SHORT, b, 8'd0, 1'b1};
        end else begin
          frame_len   = b;
          byte_cnt    = 8'd0;
          byte_sum    = 8'd0;
          parse_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        produced = 1'b1;
        res      = '{KIND_BYTE, b, byte_cnt, 1'b0};
        byte_sum = byte_sum + b;
        byte_cnt = byte_cnt + 8'd1;
        if (byte_cnt == frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        want_sum    = SUM_BASE - byte_sum;
        produced    = 1'b1;
        res         = '{(want_sum == b) ? KIND_GOOD : KIND_BAD, frame_len, 8'd0, 1'b1};
        parse_phase = PH_HUNT;
      end
      default: parse_phase = (b == START_MARK) ? PH_LEN_HI : PH_HUNT;
    endcase
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    bit            produced;
    if (rst) begin
      parse_phase = PH_HUNT;
      min_len     = MIN_LENGTH_RESET;
      frame_len   = 8'd0;
      byte_cnt    = 8'd0;
      byte_sum    = 8'd0;
      expected_q.delete();
    end else begin
      if (cfg_write) min_len = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d data %0d index %0d last %0d",
                                    kind, data, index, last));
        end else begin
          want = expected_q.pop_front();
          if (kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (data != want.data)
            report_mismatch($sformatf("data %0d, expected %0d", data, want.data));
          if (index != want.index)
            report_mismatch($sformatf("index %0d, expected %0d", index, want.index));
          if (last != want.last)
            report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(rx_byte, produced, want);
        if (produced) expected_q.push_back(want);
      end
    end
    expected_left <= expected_q.size();
  end

endmodule

// ===== dv/api_frame_receiver_tb.sv =====
// Testbench top for the API frame receiver: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module api_frame_receiver_tb;
  import afr_pkg::*;

  localparam int PHASE_ITEMS  = 180;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte   = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] index;
  logic       last;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data  = 8'd0;

  int fail_count;
  int expected_left;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cur_min       = MIN_LENGTH_RESET;
  int sent_items    = 0;
  int cycle_cnt     = 0;
  int phase_mins[8] = '{0, 255, 1, 7, -1, 254, 3, 0};

  always #5 clk = ~clk;

  api_frame_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .data     (data),
    .index    (index),
    .last     (last),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  api_frame_receiver_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data         (data),
    .index        (index),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("api_frame_receiver verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // cut < 0 sends the whole frame, otherwise only its first cut bytes
  task automatic send_frame(input int len, input bit sum_ok, input int cut);
    logic [7:0] body_sum;
    logic [7:0] b;
    int         total;
    body_sum = 8'd0;
    total    = (len < cur_min) ? 3 : len + 4;
    if (cut >= 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i == 0) begin
        b = START_MARK;
      end else if (i == 1) begin
        b = 8'($urandom);
      end else if (i == 2) begin
        b = len[7:0];
      end else if (i < len + 3) begin
        b        = 8'($urandom);
        body_sum = body_sum + b;
      end else begin
        b = SUM_BASE - body_sum;
        if (!sum_ok) b = b ^ 8'($urandom_range(1, 255));
      end
      send_byte(b);
    end
    sent_items += total;
  endtask

  function automatic int pick_length();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(252, 255);
    if (r < 20) begin
      v = cur_min - 1 + $urandom_range(0, 2);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int         r;
    int         len;
    logic [7:0] b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        drain();
        cur_min   = (phase_mins[p-1] < 0) ? $urandom_range(0, 255) : phase_mins[p-1];
        cfg_write <= 1'b1;
        cfg_data  <= cur_min[7:0];
        @(posedge clk);
        cfg_write <= 1'b0;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      sent_items = 0;
      if (p == 0) begin
        send_byte(8'h00);
        send_byte(8'hFF);
        // start mark inside the payload, length at the minimum
        send_byte(START_MARK);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(START_MARK);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h82);
        send_byte(START_MARK);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_frame(3, 1'b0, -1);
      end
      if (cur_min == 0) begin
        send_frame(0, 1'b1, -1);
        send_frame(0, 1'b0, -1);
      end
      if (cur_min >= 252) send_frame(255, 1'b1, -1);
      while (sent_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 70) begin
          send_frame(pick_length(), $urandom_range(99) < 80, -1);
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == START_MARK && $urandom_range(9) != 0) b = 8'h00;
            send_byte(b);
          end
        end else begin
          len = pick_length();
          send_frame(len, 1'b1, $urandom_range(1, len + 3));
        end
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("api_frame_receiver verification clean");
    end else begin
      $display("api_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/afr_pkg.sv
src/afr_core.sv
src/api_frame_receiver.sv
dv/api_frame_receiver_checker.sv
dv/api_frame_receiver_tb.sv
